// ----- rtl/lpa_pkg.sv -----
`timescale 1ns / 1ps
// Package for the local port allocator: word types, status codes,
// register indexes and reset values. No dependencies.
package lpa_pkg;

  localparam int unsigned PortW  = 16;
  localparam int unsigned CountW = 10;
  localparam logic [CountW-1:0] CountMax = 10'd1023;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StTaken     = 2'd1;
  localparam logic [1:0] StNoFree    = 2'd2;
  localparam logic [1:0] StNotBound  = 2'd3;

  localparam logic KindBind   = 1'b0;
  localparam logic KindUnbind = 1'b1;

  localparam logic [1:0] RegBase     = 2'd0;
  localparam logic [1:0] RegLimit    = 2'd1;
  localparam logic [1:0] RegInterval = 2'd2;

  localparam logic [15:0] BaseReset     = 16'h8000;
  localparam logic [15:0] LimitReset    = 16'hf000;
  localparam logic [3:0]  IntervalReset = 4'd10;

  typedef struct packed {
    logic              kind;
    logic [PortW-1:0]  port;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PortW-1:0]  granted_port;
  } out_word_t;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] limit;
    logic [3:0]  interval;
  } cfg_t;

endpackage

// ----- rtl/lpa_regs.sv -----
`timescale 1ns / 1ps
// APB-style configuration registers of the local port allocator.
// Depends on lpa_pkg.
module lpa_regs
  import lpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base     <= BaseReset;
      cfg_q.limit    <= LimitReset;
      cfg_q.interval <= IntervalReset;
    end else if (wr) begin
      unique case (paddr[3:2])
        RegBase:     cfg_q.base     <= pwdata[15:0];
        RegLimit:    cfg_q.limit    <= pwdata[15:0];
        RegInterval: cfg_q.interval <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegBase:     prdata = {16'd0, cfg_q.base};
      RegLimit:    prdata = {16'd0, cfg_q.limit};
      RegInterval: prdata = {28'd0, cfg_q.interval};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/local_port_allocator_top.sv -----
`timescale 1ns / 1ps
// Top level of the local port allocator: sequencer, taken-bit and count
// memories, shared reciprocal-multiply modulo unit. Depends on lpa_pkg and lpa_regs.
//
// channel | dir | handshake           | word
// in      | in  | in_valid_i/stall_o  | in_word_t  {kind, port}
// out     | out | out_valid_o/stall_i | out_word_t {status, granted_port}
// cfg     | in  | APB psel/penable    | base, limit, refresh interval
//
// After reset a clearing pass over every port address zeroes the memories; no word
// is taken meanwhile. Explicit bind/unbind: taken check, then count update if it
// passes; the bucket comes from a two-step reciprocal-multiply modulo unit.
// Automatic bind: ports probed in steps of BUCKETS, a best-bucket refresh when the
// interval runs out, or on fallback a least-loaded bucket scan and a second probe run.
// One word at a time; a finished word waits in the output register while the
// next is accepted, and a stalled full output register holds the block.
module local_port_allocator_top
  import lpa_pkg::*;
#(
  parameter int unsigned BUCKETS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned PW = PortW + 1;
  localparam int unsigned MW = 2 * PortW + 1;
  localparam int unsigned QW = PortW + BW + 1;
  localparam int unsigned RS = PortW + BW;
  localparam int unsigned RM = ((32'd1 << RS) + BUCKETS - 1) / BUCKETS;
  localparam logic [PortW:0] RecipM = (PortW+1)'(RM);
  localparam logic [BW:0] BucketsW = (BW+1)'(BUCKETS);
  localparam logic [BW-1:0] LastB = BW'(BUCKETS - 1);
  localparam logic [PW-1:0] BP = PW'(BUCKETS);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_TCHK  = 5'd2;
  localparam logic [4:0] S_MOD   = 5'd3;
  localparam logic [4:0] S_CNT   = 5'd4;
  localparam logic [4:0] S_UBR   = 5'd5;
  localparam logic [4:0] S_UBC   = 5'd6;
  localparam logic [4:0] S_UB    = 5'd7;
  localparam logic [4:0] S_SB0   = 5'd8;
  localparam logic [4:0] S_SP    = 5'd9;
  localparam logic [4:0] S_AC    = 5'd10;
  localparam logic [4:0] S_RS    = 5'd11;
  localparam logic [4:0] S_FL    = 5'd12;
  localparam logic [4:0] S_FS    = 5'd13;
  localparam logic [4:0] S_DONE  = 5'd14;

  cfg_t cfg;

  lpa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [4:0]        state_q, state_d, ret_q, ret_d;
  logic              kind_q, kind_d, fb_q, fb_d;
  logic [PortW-1:0]  port_q, port_d, gp_q, gp_d, clr_q, clr_d, r_q, r_d;
  logic [PortW-1:0]  quo_q, quo_d;
  logic [PW-1:0]     p_q, p_d;
  logic [4:0]        k_q, k_d;
  logic [BW-1:0]     md_q, md_d, sb_q, sb_d, best_q, best_d, cand_q, cand_d, i_q, i_d;
  logic [3:0]        cd_q, cd_d;
  logic [CountW-1:0] cb_q, cb_d, low_q, low_d;
  logic [1:0]        st_q, st_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;

  // taken-bit memory
  logic              tk_mem [65536];
  logic              tk_we, tk_wdata, tk_rd_q;
  logic [PortW-1:0]  tk_waddr, tk_raddr;
  // bucket count memory
  logic [CountW-1:0] cnt_mem [BUCKETS];
  logic              cnt_we;
  logic [CountW-1:0] cnt_wdata, cnt_rd_q;
  logic [BW-1:0]     cnt_waddr, cnt_raddr;

  always_ff @(posedge clk_i) begin
    if (tk_we) tk_mem[tk_waddr] <= tk_wdata;
    tk_rd_q <= tk_mem[tk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  // shared modulo: quotient by reciprocal multiply, then remainder
  logic [MW-1:0]     mprod;
  logic [QW-1:0]     qb;
  logic [BW-1:0]     rem;
  logic [BW+1:0]     off_a, off;
  logic [PW-1:0]     p_a, p_start, p_nx;
  logic [CountW-1:0] inc, dec, v_rs;
  logic [BW-1:0]     cand_fin;
  logic              in_acc;

  always_comb begin
    mprod = MW'(r_q) * MW'(RecipM);
    qb    = QW'(quo_q) * QW'(BucketsW);
    rem   = BW'(QW'(r_q) - qb);
    off_a = (BW+2)'(best_q) + (BW+2)'(BUCKETS) - (BW+2)'(md_q);
    off   = (off_a >= (BW+2)'(BUCKETS)) ? off_a - (BW+2)'(BUCKETS) : off_a;
    p_a   = PW'(cfg.base) + PW'(off);
    p_start = (p_a == '0) ? BP : p_a;
    p_nx  = p_q + BP;
    inc   = (cnt_rd_q == CountMax) ? cnt_rd_q : cnt_rd_q + 1'b1;
    dec   = (cnt_rd_q != '0) ? cnt_rd_q - 1'b1 : cnt_rd_q;
    v_rs  = (i_q == best_q) ? cb_q : cnt_rd_q;
    cand_fin = (cnt_rd_q < low_q) ? i_q : cand_q;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d = state_q;  ret_d = ret_q;  kind_d = kind_q;  fb_d = fb_q;
    port_d = port_q;    gp_d = gp_q;    clr_d = clr_q;    p_d = p_q;
    r_d = r_q;          k_d = k_q;      md_d = md_q;      sb_d = sb_q;
    best_d = best_q;    cand_d = cand_q; i_d = i_q;       cd_d = cd_q;
    cb_d = cb_q;        low_d = low_q;  st_d = st_q;      quo_d = quo_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_word_d  = out_word_q;
    tk_we = 1'b0;  tk_wdata = 1'b0;  tk_waddr = port_q;  tk_raddr = port_q;
    cnt_we = 1'b0; cnt_wdata = '0;   cnt_waddr = sb_q;   cnt_raddr = best_q;

    unique case (state_q)
      S_CLEAR: begin
        tk_we = 1'b1;
        tk_waddr = clr_q;
        cnt_we = (32'(clr_q) < BUCKETS);
        cnt_waddr = clr_q[BW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        tk_raddr = in_word_i.port;
        if (in_acc) begin
          kind_d = in_word_i.kind;
          port_d = in_word_i.port;
          gp_d   = '0;
          fb_d   = 1'b0;
          if (in_word_i.port != '0) begin
            state_d = S_TCHK;
          end else if (in_word_i.kind == KindUnbind) begin
            st_d = StNotBound;
            state_d = S_DONE;
          end else begin
            r_d = cfg.base;
            k_d = 5'd1;
            ret_d = S_SB0;
            state_d = S_MOD;
          end
        end
      end
      S_TCHK: begin
        r_d = port_q;
        k_d = 5'd1;
        ret_d = S_CNT;
        if (kind_q == KindBind) begin
          if (tk_rd_q) begin
            st_d = StTaken;
            state_d = S_DONE;
          end else begin
            tk_we = 1'b1;
            tk_wdata = 1'b1;
            state_d = S_MOD;
          end
        end else begin
          if (!tk_rd_q) begin
            st_d = StNotBound;
            state_d = S_DONE;
          end else begin
            tk_we = 1'b1;
            state_d = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (k_q != '0) begin
          quo_d = PortW'(mprod >> RS);
          k_d = k_q - 1'b1;
        end else begin
          md_d = rem;
          cnt_raddr = rem;
          state_d = ret_q;
        end
      end
      S_CNT: begin
        cnt_we = 1'b1;
        cnt_waddr = md_q;
        cnt_wdata = (kind_q == KindBind) ? inc : dec;
        cb_d = cnt_wdata;
        sb_d = md_q;
        st_d = StOk;
        gp_d = port_q;
        cnt_raddr = best_q;
        state_d = S_UB;
      end
      S_UBR: begin
        cnt_raddr = sb_q;
        state_d = S_UBC;
      end
      S_UBC: begin
        cb_d = cnt_rd_q;
        cnt_raddr = best_q;
        state_d = S_UB;
      end
      S_UB: begin
        if (sb_q != best_q && cb_q < cnt_rd_q) best_d = sb_q;
        state_d = S_DONE;
      end
      S_SB0: begin
        p_d = p_start;
        sb_d = best_q;
        tk_raddr = p_start[PortW-1:0];
        state_d = S_SP;
      end
      S_SP: begin
        if (p_q >= PW'(cfg.limit)) begin
          if (fb_q) begin
            st_d = StNoFree;
            state_d = S_DONE;
          end else begin
            cnt_raddr = best_q;
            state_d = S_FL;
          end
        end else if (!tk_rd_q) begin
          tk_we = 1'b1;
          tk_wdata = 1'b1;
          tk_waddr = p_q[PortW-1:0];
          cnt_raddr = best_q;
          state_d = S_AC;
        end else begin
          p_d = p_nx;
          tk_raddr = p_nx[PortW-1:0];
        end
      end
      S_AC: begin
        cnt_we = 1'b1;
        cnt_waddr = best_q;
        cnt_wdata = inc;
        cb_d = inc;
        st_d = StOk;
        gp_d = p_q[PortW-1:0];
        state_d = S_UBR;
        if (!fb_q) begin
          if (cd_q <= 4'd1) begin
            cd_d = cfg.interval;
            i_d = '0;
            cnt_raddr = '0;
            state_d = S_RS;
          end else begin
            cd_d = cd_q - 1'b1;
          end
        end
      end
      S_RS: begin
        if (v_rs < cb_q) begin
          best_d = i_q;
          state_d = S_UBR;
        end else if (i_q == LastB) begin
          state_d = S_UBR;
        end else begin
          i_d = i_q + 1'b1;
          cnt_raddr = i_d;
        end
      end
      S_FL: begin
        low_d = cnt_rd_q;
        cand_d = best_q;
        i_d = '0;
        cnt_raddr = '0;
        state_d = S_FS;
      end
      S_FS: begin
        if (cnt_rd_q < low_q) begin
          low_d = cnt_rd_q;
          cand_d = i_q;
        end
        if (i_q == LastB) begin
          if (cand_fin == best_q) begin
            st_d = StNoFree;
            state_d = S_DONE;
          end else begin
            best_d = cand_fin;
            cd_d = cfg.interval;
            fb_d = 1'b1;
            state_d = S_SB0;
          end
        end else begin
          i_d = i_q + 1'b1;
          cnt_raddr = i_d;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_word_d.status = st_q;
          out_word_d.granted_port = gp_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      best_q <= '0;
      cd_q <= IntervalReset;
      out_valid_q <= 1'b0;
      ret_q <= S_IDLE;
      fb_q <= 1'b0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      best_q <= best_d;
      cd_q <= cd_d;
      out_valid_q <= out_valid_d;
      ret_q <= ret_d;
      fb_q <= fb_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;  port_q <= port_d;  gp_q <= gp_d;  p_q <= p_d;
    r_q <= r_d;        md_q <= md_d;      sb_q <= sb_d;  cand_q <= cand_d;
    i_q <= i_d;        cb_q <= cb_d;      low_q <= low_d; st_q <= st_d;
    quo_q <= quo_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOD |-> k_q <= 5'd1) else $error("modulo step out of range");
  a_best_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(best_q) < BUCKETS) else $error("best bucket out of range");
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE) else $error("accept left block idle");
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || !out_stall_i)) |=> out_valid_q)
    else $error("finished word not presented");

endmodule
